// ===== rtl/foc_voltage_to_pwm_duty_macros.svh =====
`ifndef FOC_VOLTAGE_TO_PWM_DUTY_MACROS_SVH
`define FOC_VOLTAGE_TO_PWM_DUTY_MACROS_SVH

// implication checked on every clock edge out of reset
`define FVPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fvpd assertion failed");

// next-cycle implication
`define FVPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fvpd assertion failed");

`endif

// ===== rtl/fvpd_pkg.sv =====
`timescale 1ns / 1ps
package fvpd_pkg;
	localparam int CW      = 34;
	localparam int ZW      = 17;
	localparam int PW      = 50;
	localparam int SW      = 51;
	localparam int MW      = 36;
	localparam int UW      = 38;
	localparam int QW      = 15;
	localparam int RW      = 31;
	localparam int CSTAGES = 16;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [ZW-1:0] angle_t;
	typedef logic [RW-1:0] rem_t;
	typedef logic [QW-1:0] quot_t;

	function automatic angle_t atan_of(input logic [3:0] i);
		angle_t r;
		case (i)
			4'd0: r = 17'sd8192;
			4'd1: r = 17'sd4836;
			4'd2: r = 17'sd2555;
			4'd3: r = 17'sd1297;
			4'd4: r = 17'sd651;
			4'd5: r = 17'sd326;
			4'd6: r = 17'sd163;
			4'd7: r = 17'sd81;
			4'd8: r = 17'sd41;
			4'd9: r = 17'sd20;
			4'd10: r = 17'sd10;
			4'd11: r = 17'sd5;
			4'd12: r = 17'sd3;
			4'd13: r = 17'sd1;
			4'd14: r = 17'sd1;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction
endpackage

// ===== rtl/fvpd_cordic_cell.sv =====
`timescale 1ns / 1ps
module fvpd_cordic_cell (
	input  logic             clk,
	input  logic             en,
	input  logic [3:0]       stage,
	input  fvpd_pkg::coord_t x_in,
	input  fvpd_pkg::coord_t y_in,
	input  fvpd_pkg::angle_t z_in,
	output fvpd_pkg::coord_t x_s1,
	output fvpd_pkg::coord_t y_s1,
	output fvpd_pkg::angle_t z_s1
);
	fvpd_pkg::coord_t dx, dy;
	fvpd_pkg::angle_t at;

	assign dx = y_in >>> stage;
	assign dy = x_in >>> stage;
	assign at = fvpd_pkg::atan_of(stage);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[fvpd_pkg::ZW-1]) begin
				x_s1 <= x_in - dx;
				y_s1 <= y_in + dy;
				z_s1 <= z_in - at;
			end else begin
				x_s1 <= x_in + dx;
				y_s1 <= y_in - dy;
				z_s1 <= z_in + at;
			end
		end
	end
endmodule

// ===== rtl/fvpd_div_cell.sv =====
`timescale 1ns / 1ps
module fvpd_div_cell (
	input  logic            clk,
	input  logic            en,
	input  logic [3:0]      bit_idx,
	input  logic [15:0]     dval,
	input  fvpd_pkg::rem_t  rem_in,
	input  fvpd_pkg::quot_t q_in,
	output fvpd_pkg::rem_t  rem_s1,
	output fvpd_pkg::quot_t q_s1
);
	fvpd_pkg::rem_t trial;
	logic           take;

	assign trial = fvpd_pkg::rem_t'(dval) << bit_idx;
	assign take  = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= take ? rem_in - trial : rem_in;
			q_s1   <= q_in | (fvpd_pkg::quot_t'(take) << bit_idx);
		end
	end
endmodule

// ===== rtl/foc_voltage_to_pwm_duty.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle while out_ready does not stall; a 38-stage pipeline of CORDIC,
// transform and one-bit-per-stage divider cells, with per-stage valids so bubbles close up.
// Reset (arst_n low, asynchronous): pipeline emptied, bus_voltage set to 16384.
module foc_voltage_to_pwm_duty (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        theta,
	input  logic signed [15:0] vd,
	input  logic signed [15:0] vq,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        duty_a,
	output logic [15:0]        duty_b,
	output logic [15:0]        duty_c,
	output logic               clamped
);
	localparam int NS    = 38;
	localparam int ST_G  = 17;
	localparam int ST_K1 = 18;
	localparam int ST_K2 = 19;
	localparam int ST_M1 = 20;
	localparam int ST_M2 = 21;
	localparam int ST_D0 = 22;
	localparam logic signed [15:0] GAIN = 16'sd19898;
	localparam logic signed [15:0] SQ3  = 16'sd28378;

	logic [14:0]   bus_q;
	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {17'd0, bus_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= 15'd16384;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			bus_q <= pwdata[14:0];
		end
	end

	// per-stage advance
	always_comb begin
		en[NS-1] = !v_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// quadrant pre-rotation
	logic [15:0]      tsum;
	fvpd_pkg::coord_t xd, yd, xp, yp;
	fvpd_pkg::angle_t zp;

	assign tsum = theta + 16'd8192;
	assign zp   = $signed({3'b000, tsum[13:0]}) - 17'sd8192;
	assign xd   = fvpd_pkg::coord_t'(vd) <<< 14;
	assign yd   = fvpd_pkg::coord_t'(vq) <<< 14;

	always_comb begin
		case (tsum[15:14])
			2'd1: begin
				xp = -yd;
				yp = xd;
			end
			2'd2: begin
				xp = -xd;
				yp = -yd;
			end
			2'd3: begin
				xp = yd;
				yp = -xd;
			end
			default: begin
				xp = xd;
				yp = yd;
			end
		endcase
	end

	fvpd_pkg::coord_t cx [0:fvpd_pkg::CSTAGES];
	fvpd_pkg::coord_t cy [0:fvpd_pkg::CSTAGES];
	fvpd_pkg::angle_t cz [0:fvpd_pkg::CSTAGES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cx[0] <= xp;
			cy[0] <= yp;
			cz[0] <= zp;
		end
	end

	for (genvar i = 0; i < fvpd_pkg::CSTAGES; i++) begin : g_cordic
		fvpd_cordic_cell u_cell (
			.clk   (clk),
			.en    (en[i+1]),
			.stage (4'(i)),
			.x_in  (cx[i]),
			.y_in  (cy[i]),
			.z_in  (cz[i]),
			.x_s1  (cx[i+1]),
			.y_s1  (cy[i+1]),
			.z_s1  (cz[i+1])
		);
	end

	// gain compensation
	logic signed [fvpd_pkg::PW-1:0] gpx, gpy;
	fvpd_pkg::coord_t gx_s17, gy_s17;

	assign gpx = cx[fvpd_pkg::CSTAGES] * GAIN;
	assign gpy = cy[fvpd_pkg::CSTAGES] * GAIN;

	always_ff @(posedge clk) begin
		if (en[ST_G]) begin
			gx_s17 <= gpx[fvpd_pkg::CW+14:15];
			gy_s17 <= gpy[fvpd_pkg::CW+14:15];
		end
	end

	// inverse Clarke
	fvpd_pkg::coord_t               ax_s18;
	logic signed [fvpd_pkg::PW-1:0] by_s18;

	always_ff @(posedge clk) begin
		if (en[ST_K1]) begin
			ax_s18 <= gx_s17;
			by_s18 <= gy_s17 * SQ3;
		end
	end

	logic signed [fvpd_pkg::SW-1:0] ax14, sb, sc;
	fvpd_pkg::coord_t               va_s19, vb_s19, vc_s19;

	assign ax14 = fvpd_pkg::SW'(ax_s18) <<< 14;
	assign sb   = fvpd_pkg::SW'(by_s18) - ax14;
	assign sc   = -ax14 - fvpd_pkg::SW'(by_s18);

	always_ff @(posedge clk) begin
		if (en[ST_K2]) begin
			va_s19 <= ax_s18;
			vb_s19 <= sb[fvpd_pkg::CW+14:15];
			vc_s19 <= sc[fvpd_pkg::CW+14:15];
		end
	end

	// min-max injection
	fvpd_pkg::coord_t               mx, mn;
	logic signed [fvpd_pkg::MW-1:0] mm;
	logic signed [fvpd_pkg::MW-1:0] m_s20 [3];

	always_comb begin
		mx = va_s19;
		mn = va_s19;
		if (vb_s19 > mx) mx = vb_s19;
		if (vc_s19 > mx) mx = vc_s19;
		if (vb_s19 < mn) mn = vb_s19;
		if (vc_s19 < mn) mn = vc_s19;
		mm = fvpd_pkg::MW'(mx) + fvpd_pkg::MW'(mn);
	end

	always_ff @(posedge clk) begin
		if (en[ST_M1]) begin
			m_s20[0] <= (fvpd_pkg::MW'(va_s19) <<< 1) - mm;
			m_s20[1] <= (fvpd_pkg::MW'(vb_s19) <<< 1) - mm;
			m_s20[2] <= (fvpd_pkg::MW'(vc_s19) <<< 1) - mm;
		end
	end

	// divider set-up: floor division via one's complement of negative numerators
	logic [14:0]     busd;
	logic [15:0]     dval;
	fvpd_pkg::rem_t  rem_d [0:fvpd_pkg::QW][3];
	fvpd_pkg::quot_t q_d   [0:fvpd_pkg::QW][3];
	logic            sat_d [0:fvpd_pkg::QW][3];
	logic            neg_d [0:fvpd_pkg::QW][3];

	assign busd = (bus_q == 15'd0) ? 15'd1 : bus_q;
	assign dval = {busd, 1'b0};

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [fvpd_pkg::UW-1:0] n;
		logic [fvpd_pkg::UW-1:0]        u;

		assign n = (fvpd_pkg::UW'(m_s20[l]) <<< 1) + $signed({23'd0, busd});
		assign u = n[fvpd_pkg::UW-1] ? ~n : n;

		always_ff @(posedge clk) begin
			if (en[ST_M2]) begin
				rem_d[0][l] <= u[fvpd_pkg::RW-1:0];
				q_d[0][l]   <= '0;
				sat_d[0][l] <= u >= (fvpd_pkg::UW'(dval) << fvpd_pkg::QW);
				neg_d[0][l] <= n[fvpd_pkg::UW-1];
			end
		end

		for (genvar j = 0; j < fvpd_pkg::QW; j++) begin : g_div
			fvpd_div_cell u_cell (
				.clk     (clk),
				.en      (en[ST_D0+j]),
				.bit_idx (4'(fvpd_pkg::QW - 1 - j)),
				.dval    (dval),
				.rem_in  (rem_d[j][l]),
				.q_in    (q_d[j][l]),
				.rem_s1  (rem_d[j+1][l]),
				.q_s1    (q_d[j+1][l])
			);

			always_ff @(posedge clk) begin
				if (en[ST_D0+j]) begin
					sat_d[j+1][l] <= sat_d[j][l];
					neg_d[j+1][l] <= neg_d[j][l];
				end
			end
		end
	end

	// offset and clamp
	logic [15:0] dy  [3];
	logic        clp [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [14:0] qq;
			logic [16:0] s;
			qq = sat_d[fvpd_pkg::QW][l] ? 15'h7FFF : q_d[fvpd_pkg::QW][l];
			s  = 17'd16384 + 17'(qq);
			if (neg_d[fvpd_pkg::QW][l]) begin
				clp[l] = qq > 15'd16383;
				dy[l]  = clp[l] ? 16'd0 : 16'd16383 - 16'(qq);
			end else begin
				clp[l] = s > 17'd32768;
				dy[l]  = clp[l] ? 16'd32768 : s[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			duty_a  <= dy[0];
			duty_b  <= dy[1];
			duty_c  <= dy[2];
			clamped <= clp[0] | clp[1] | clp[2];
		end
	end
endmodule

// ===== rtl/fvpd_checker.sv =====
`timescale 1ns / 1ps
`include "foc_voltage_to_pwm_duty_macros.svh"
module fvpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] duty_a,
	input logic [15:0] duty_b,
	input logic [15:0] duty_c,
	input logic        clamped
);
	`FVPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duty_a) && $stable(duty_b) && $stable(duty_c) && $stable(clamped))
	`FVPD_ASSERT_IMPL(a_duty_range, out_valid, duty_a <= 16'd32768 && duty_b <= 16'd32768 && duty_c <= 16'd32768)
	`FVPD_ASSERT_IMPL(a_pready, 1'b1, pready)
endmodule

bind foc_voltage_to_pwm_duty fvpd_checker u_fvpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.duty_a    (duty_a),
	.duty_b    (duty_b),
	.duty_c    (duty_c),
	.clamped   (clamped)
);
